// File: rtl/sm3_pkg.sv
// sm3_pkg: shared types, constants and helper functions for the SM3 hash core.
// No dependencies; imported by every module in rtl/.
`timescale 1ns / 1ps

package sm3_pkg;

    localparam int CvDepth     = 8;
    localparam int WindowDepth = 16;
    localparam int RoundNum    = 64;

    localparam logic [31:0]  TLow  = 32'h79cc4519;
    localparam logic [31:0]  THigh = 32'h7a879d8a;
    localparam logic [255:0] Iv    =
        256'h7380166F4914B2B9172442D7DA8A0600A96F30BC163138AAE38DEE4DB0FB0E4E;

    typedef struct packed {
        logic [31:0] message_word;
        logic        final_block;
    } sm3_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } sm3_out_t;

    // message window control
    typedef struct packed {
        logic shift_en;
        logic expand;
    } sm3_sched_ctrl_t;

    // working register control
    typedef struct packed {
        logic shift_en;
        logic round_en;
    } sm3_comp_ctrl_t;

    function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] r);
        logic [63:0] d;
        d = {x, x} << r;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(logic [31:0] x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(logic [31:0] x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

    // IV word i, word 0 is the most significant
    function automatic logic [31:0] iv_word(logic [2:0] i);
        logic [2:0] k;
        k = 3'd7 - i;
        return Iv[k*32 +: 32];
    endfunction

    // round constant already rotated by j mod 32
    function automatic logic [31:0] tj_rot(logic [5:0] j);
        logic [31:0] t;
        t = (j[5:4] != 2'd0) ? THigh : TLow;
        return rotl32(t, j[4:0]);
    endfunction

endpackage

// File: rtl/sm3_cv_store.sv
// sm3_cv_store: 8 x 32 chaining value memory, one read and one write port,
// registered read data, per-entry valid bits so an unwritten entry reads as IV.
// Depends on sm3_pkg.
`timescale 1ns / 1ps

module sm3_cv_store (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        rd_en,
    input  logic [2:0]  rd_addr,
    output logic [31:0] rd_data,
    input  logic        wr_en,
    input  logic [2:0]  wr_addr,
    input  logic [31:0] wr_data,
    input  logic        clear
);
    import sm3_pkg::*;

    logic [31:0] cv_mem [CvDepth];
    logic [CvDepth-1:0] valid_reg;
    logic [31:0] rd_data_reg;
    logic        rd_valid_reg;
    logic [2:0]  rd_addr_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cv_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= cv_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // clear wins over a same-cycle write: entries go back to IV
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : iv_word(rd_addr_reg);

endmodule

// File: rtl/sm3_msg_sched.sv
// sm3_msg_sched: 16-word message window; collects input words and produces
// W[j+16] on the fly during the rounds. Depends on sm3_pkg.
`timescale 1ns / 1ps

module sm3_msg_sched (
    input  logic                      aclk,
    input  sm3_pkg::sm3_sched_ctrl_t  ctrl,
    input  logic [31:0]               in_word,
    output logic [31:0]               wj,
    output logic [31:0]               wj4
);
    import sm3_pkg::*;

    logic [31:0] win_reg [WindowDepth];
    logic [31:0] expanded;

    // win_reg[0] holds W[j]
    assign expanded = perm1(win_reg[0] ^ win_reg[7] ^ rotl32(win_reg[13], 5'd15))
                    ^ rotl32(win_reg[3], 5'd7) ^ win_reg[10];

    always_ff @(posedge aclk) begin
        if (ctrl.shift_en) begin
            for (int k = 0; k < WindowDepth - 1; k++) begin
                win_reg[k] <= win_reg[k+1];
            end
            win_reg[WindowDepth-1] <= ctrl.expand ? expanded : in_word;
        end
    end

    assign wj  = win_reg[0];
    assign wj4 = win_reg[4];

endmodule

// File: rtl/sm3_compress.sv
// sm3_compress: working registers A..H and the one-round-per-cycle compression
// function; also a plain shift path for load, write-back and digest readout.
// Depends on sm3_pkg.
`timescale 1ns / 1ps

module sm3_compress (
    input  logic                     aclk,
    input  sm3_pkg::sm3_comp_ctrl_t  ctrl,
    input  logic [5:0]               round_idx,
    input  logic [31:0]              wj,
    input  logic [31:0]              wj4,
    input  logic [31:0]              shift_data,
    output logic [31:0]              head
);
    import sm3_pkg::*;

    logic [31:0] wr_reg [CvDepth];
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;
    logic        late;

    always_comb begin
        late = (round_idx[5:4] != 2'd0);
        a12  = rotl32(wr_reg[0], 5'd12);
        ss1  = rotl32(a12 + wr_reg[4] + tj_rot(round_idx), 5'd7);
        ss2  = ss1 ^ a12;
        ff   = late ? ((wr_reg[0] & wr_reg[1]) | (wr_reg[1] & wr_reg[2])
                     | (wr_reg[0] & wr_reg[2]))
                    : (wr_reg[0] ^ wr_reg[1] ^ wr_reg[2]);
        gg   = late ? ((wr_reg[4] & wr_reg[5]) | (~wr_reg[4] & wr_reg[6]))
                    : (wr_reg[4] ^ wr_reg[5] ^ wr_reg[6]);
        tt1  = ff + wr_reg[3] + ss2 + (wj ^ wj4);
        tt2  = gg + wr_reg[7] + ss1 + wj;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.round_en) begin
            wr_reg[3] <= wr_reg[2];
            wr_reg[2] <= rotl32(wr_reg[1], 5'd9);
            wr_reg[1] <= wr_reg[0];
            wr_reg[0] <= tt1;
            wr_reg[7] <= wr_reg[6];
            wr_reg[6] <= rotl32(wr_reg[5], 5'd19);
            wr_reg[5] <= wr_reg[4];
            wr_reg[4] <= perm0(tt2);
        end else if (ctrl.shift_en) begin
            for (int k = 0; k < CvDepth - 1; k++) begin
                wr_reg[k] <= wr_reg[k+1];
            end
            wr_reg[CvDepth-1] <= shift_data;
        end
    end

    assign head = wr_reg[0];

endmodule

// File: rtl/sm3_hash_core_unit.sv
// sm3_hash_core_unit: SM3 hash core over pre-padded 32-bit big-endian words.
// After the 16th word of a final block, the core loads the CV into A..H, runs the rounds,
//   writes the new CV back and then moves the digest words through the output register.
// No input word is taken during load, rounds and write-back; during digest readout the
//   words of the next block may arrive, but not its 16th word.
// Reset: aresetn (sync, active low) clears control and CV valid bits; CV reads as IV.
`timescale 1ns / 1ps

module sm3_hash_core_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sm3_pkg::sm3_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output sm3_pkg::sm3_out_t m_payload
);
    import sm3_pkg::*;

    // Flow per block:
    //   IDLE  : words shift into the message window, word_cnt counts them.
    //   LOAD  : sweep CV memory 0..7 into A..H (one read per cycle, data in the next cycle).
    //   ROUND : 64 rounds, window expands W[j+16] in the same cycle.
    //   WB    : sweep CV again, write CV ^ A..H back; new CV also lands in A..H.
    //           A final block clears the CV valid bits (back to IV) on the last cycle.
    //   EMIT  : rotate A..H out through the output register, one request per word.
    // WB reads entry p while writing entry p-1, so the same entry is never
    // read and written in one cycle and no forwarding path is needed.

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [3:0] PhaseSweepEnd = 4'd8;
    localparam logic [3:0] PhaseEmitEnd  = 4'd7;
    localparam logic [3:0] WordLast      = 4'd15;
    localparam logic [5:0] RoundLast     = 6'(RoundNum - 1);

    logic [2:0]  state_reg, state_next;
    logic [3:0]  word_cnt_reg, word_cnt_next;
    logic [3:0]  phase_reg, phase_next;
    logic [5:0]  round_reg, round_next;
    logic        final_reg, final_next;
    logic        m_valid_reg, m_valid_next;
    sm3_out_t    m_payload_reg, m_payload_next;

    logic        s_fire;
    logic        out_load;

    sm3_sched_ctrl_t sched_ctrl;
    sm3_comp_ctrl_t  comp_ctrl;
    logic [31:0]     wj, wj4, head, shift_data;

    logic        rd_en, wr_en, cv_clear;
    logic [2:0]  rd_addr, wr_addr;
    logic [31:0] rd_data, wr_data;

    // words may keep arriving while the digest drains, but not the one that
    // would start the next block
    assign s_ready = (state_reg == ST_IDLE)
                  || (state_reg == ST_EMIT && word_cnt_reg != WordLast);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        phase_next     = phase_reg;
        round_next     = round_reg;
        final_next     = final_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;

        sched_ctrl.shift_en = s_fire;
        sched_ctrl.expand   = 1'b0;
        comp_ctrl.shift_en  = 1'b0;
        comp_ctrl.round_en  = 1'b0;
        shift_data          = rd_data;

        rd_en    = 1'b0;
        rd_addr  = phase_reg[2:0];
        wr_en    = 1'b0;
        wr_addr  = phase_reg[2:0] - 3'd1;
        wr_data  = rd_data ^ head;
        cv_clear = 1'b0;
        out_load = 1'b0;

        if (s_fire) begin
            word_cnt_next = word_cnt_reg + 4'd1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && word_cnt_reg == WordLast) begin
                    // only the flag with the 16th word counts
                    final_next = s_payload.final_block;
                    phase_next = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                rd_en              = (phase_reg != PhaseSweepEnd);
                comp_ctrl.shift_en = (phase_reg != 4'd0);
                phase_next         = phase_reg + 4'd1;
                if (phase_reg == PhaseSweepEnd) begin
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                comp_ctrl.round_en  = 1'b1;
                sched_ctrl.shift_en = 1'b1;
                sched_ctrl.expand   = 1'b1;
                round_next          = round_reg + 6'd1;
                if (round_reg == RoundLast) begin
                    phase_next = '0;
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                rd_en              = (phase_reg != PhaseSweepEnd);
                wr_en              = (phase_reg != 4'd0);
                comp_ctrl.shift_en = (phase_reg != 4'd0);
                shift_data         = wr_data;
                phase_next         = phase_reg + 4'd1;
                if (phase_reg == PhaseSweepEnd) begin
                    cv_clear   = final_reg;
                    phase_next = '0;
                    state_next = final_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                out_load = !m_valid_reg || m_ready;
                if (out_load) begin
                    m_valid_next               = 1'b1;
                    m_payload_next.digest_word = head;
                    m_payload_next.word_index  = phase_reg[2:0];
                    m_payload_next.last        = (phase_reg == PhaseEmitEnd);
                    comp_ctrl.shift_en         = 1'b1;
                    shift_data                 = head;
                    phase_next                 = phase_reg + 4'd1;
                    if (phase_reg == PhaseEmitEnd) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            word_cnt_reg <= '0;
            phase_reg    <= '0;
            round_reg    <= '0;
            final_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            word_cnt_reg <= word_cnt_next;
            phase_reg    <= phase_next;
            round_reg    <= round_next;
            final_reg    <= final_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload: no reset needed
    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    sm3_cv_store u_cv_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .clear   (cv_clear)
    );

    sm3_msg_sched u_msg_sched (
        .aclk    (aclk),
        .ctrl    (sched_ctrl),
        .in_word (s_payload.message_word),
        .wj      (wj),
        .wj4     (wj4)
    );

    sm3_compress u_compress (
        .aclk       (aclk),
        .ctrl       (comp_ctrl),
        .round_idx  (round_reg),
        .wj         (wj),
        .wj4        (wj4),
        .shift_data (shift_data),
        .head       (head)
    );

    // round 63 always hands over to write-back
    property p_round_to_wb;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == RoundLast) |=> (state_reg == ST_WB);
    endproperty
    a_round_to_wb: assert property (p_round_to_wb)
        else $error("round sweep did not end in write-back");

    // a digest request only starts out of the readout phase
    property p_emit_source;
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_EMIT);
    endproperty
    a_emit_source: assert property (p_emit_source)
        else $error("result request raised outside readout");

    // while busy on a block, the word counter sits at zero and no word is taken
    property p_busy_no_input;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD || state_reg == ST_ROUND || state_reg == ST_WB)
            |-> (word_cnt_reg == 4'd0 && !s_ready);
    endproperty
    a_busy_no_input: assert property (p_busy_no_input)
        else $error("input taken or counter nonzero during compression");

    // last flag marks word seven only
    property p_last_index;
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_payload_reg.last == (m_payload_reg.word_index == 3'd7));
    endproperty
    a_last_index: assert property (p_last_index)
        else $error("last flag and word index disagree");

endmodule
